>>> src/sct_pkg.sv
package sct_pkg;

   localparam int POS_W = 48;
   localparam int VEL_W = 32;
   localparam int RAD_W = 32;
   localparam int TIME_W = 32;
   localparam int FRAC_W = 16;

   localparam int PDIF_W = POS_W + 1;
   localparam int VDIF_W = VEL_W + 1;
   localparam int DSUM_W = RAD_W + 1;

   localparam int REQ_DATA_W = 3 * POS_W + 3 * VEL_W + RAD_W;
   localparam int RSP_DATA_W = TIME_W;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TEST = 1'b1;

   // multiplier limb and quadratic term widths
   localparam int LIMB_W = 33;
   localparam int PROD_W = 2 * LIMB_W;
   localparam int ACC_W = 168;
   localparam int A_W = 66;
   localparam int HN_W = 82;
   localparam int C_W = 98;
   localparam int DD_W = 164;

   localparam int ROOT_STEPS = 82;
   localparam int ROOT_BIT0 = 2 * (ROOT_STEPS - 1);
   localparam int DIV_STEPS = TIME_W + 1;
   localparam int CNT_W = 7;

   // operand limb codes
   localparam int SRC_W = 5;
   localparam int SRC_COUNT = 18;
   localparam logic [SRC_W-1:0] SRC_VX  = 5'd0;
   localparam logic [SRC_W-1:0] SRC_VY  = 5'd1;
   localparam logic [SRC_W-1:0] SRC_VZ  = 5'd2;
   localparam logic [SRC_W-1:0] SRC_PX0 = 5'd3;
   localparam logic [SRC_W-1:0] SRC_PX1 = 5'd4;
   localparam logic [SRC_W-1:0] SRC_PY0 = 5'd5;
   localparam logic [SRC_W-1:0] SRC_PY1 = 5'd6;
   localparam logic [SRC_W-1:0] SRC_PZ0 = 5'd7;
   localparam logic [SRC_W-1:0] SRC_PZ1 = 5'd8;
   localparam logic [SRC_W-1:0] SRC_D   = 5'd9;
   localparam logic [SRC_W-1:0] SRC_H0  = 5'd10;
   localparam logic [SRC_W-1:0] SRC_H1  = 5'd11;
   localparam logic [SRC_W-1:0] SRC_H2  = 5'd12;
   localparam logic [SRC_W-1:0] SRC_A0  = 5'd13;
   localparam logic [SRC_W-1:0] SRC_A1  = 5'd14;
   localparam logic [SRC_W-1:0] SRC_C0  = 5'd15;
   localparam logic [SRC_W-1:0] SRC_C1  = 5'd16;
   localparam logic [SRC_W-1:0] SRC_C2  = 5'd17;

   // product sign codes; NPV* subtracts p*v when both have the same sign
   localparam int SGN_W = 3;
   localparam logic [SGN_W-1:0] SGN_ADD  = 3'd0;
   localparam logic [SGN_W-1:0] SGN_SUB  = 3'd1;
   localparam logic [SGN_W-1:0] SGN_NPVX = 3'd2;
   localparam logic [SGN_W-1:0] SGN_NPVY = 3'd3;
   localparam logic [SGN_W-1:0] SGN_NPVZ = 3'd4;

   // accumulator latch targets
   localparam int LAT_W = 3;
   localparam logic [LAT_W-1:0] LAT_NONE = 3'd0;
   localparam logic [LAT_W-1:0] LAT_A    = 3'd1;
   localparam logic [LAT_W-1:0] LAT_H    = 3'd2;
   localparam logic [LAT_W-1:0] LAT_C    = 3'd3;
   localparam logic [LAT_W-1:0] LAT_D    = 3'd4;

   localparam int SHIFT_W = 3;
   localparam int OP_COUNT = 37;
   localparam int OP_W = 6;

   typedef struct packed {
      logic [SRC_W-1:0]   src_a;
      logic [SRC_W-1:0]   src_b;
      logic [SHIFT_W-1:0] shift;
      logic [SGN_W-1:0]   sgn;
      logic [LAT_W-1:0]   lat;
   } mac_op_type;

   typedef struct packed {
      logic [2:0][POS_W-1:0] p_mag;
      logic [2:0]            p_neg;
      logic [2:0][VEL_W-1:0] v_mag;
      logic [2:0]            v_neg;
      logic [DSUM_W-1:0]     d_sum;
   } rel_type;

   typedef struct packed {
      logic [A_W-1:0]  a;
      logic [HN_W-1:0] hn;
      logic [DD_W-1:0] dd;
      logic            a_nz;
      logic            hn_pos;
      logic            c_pos;
      logic            dd_neg;
   } quad_type;

   function automatic mac_op_type mk_op(input logic [SRC_W-1:0] sa,
                                        input logic [SRC_W-1:0] sb,
                                        input logic [SHIFT_W-1:0] sh,
                                        input logic [SGN_W-1:0] sg,
                                        input logic [LAT_W-1:0] lt);
      mac_op_type r;
      r.src_a = sa;
      r.src_b = sb;
      r.shift = sh;
      r.sgn = sg;
      r.lat = lt;
      return r;
   endfunction

   // a = |v|^2, -h = -(p.v), c = |p|^2 - d^2, D = h^2 - a*c
   function automatic mac_op_type mac_op(input logic [OP_W-1:0] idx);
      mac_op_type r;
      unique case (idx)
         6'd0:  r = mk_op(SRC_VX,  SRC_VX,  3'd0, SGN_ADD,  LAT_NONE);
         6'd1:  r = mk_op(SRC_VY,  SRC_VY,  3'd0, SGN_ADD,  LAT_NONE);
         6'd2:  r = mk_op(SRC_VZ,  SRC_VZ,  3'd0, SGN_ADD,  LAT_A);
         6'd3:  r = mk_op(SRC_PX0, SRC_VX,  3'd0, SGN_NPVX, LAT_NONE);
         6'd4:  r = mk_op(SRC_PX1, SRC_VX,  3'd1, SGN_NPVX, LAT_NONE);
         6'd5:  r = mk_op(SRC_PY0, SRC_VY,  3'd0, SGN_NPVY, LAT_NONE);
         6'd6:  r = mk_op(SRC_PY1, SRC_VY,  3'd1, SGN_NPVY, LAT_NONE);
         6'd7:  r = mk_op(SRC_PZ0, SRC_VZ,  3'd0, SGN_NPVZ, LAT_NONE);
         6'd8:  r = mk_op(SRC_PZ1, SRC_VZ,  3'd1, SGN_NPVZ, LAT_H);
         6'd9:  r = mk_op(SRC_PX0, SRC_PX0, 3'd0, SGN_ADD,  LAT_NONE);
         6'd10: r = mk_op(SRC_PX0, SRC_PX1, 3'd1, SGN_ADD,  LAT_NONE);
         6'd11: r = mk_op(SRC_PX1, SRC_PX0, 3'd1, SGN_ADD,  LAT_NONE);
         6'd12: r = mk_op(SRC_PX1, SRC_PX1, 3'd2, SGN_ADD,  LAT_NONE);
         6'd13: r = mk_op(SRC_PY0, SRC_PY0, 3'd0, SGN_ADD,  LAT_NONE);
         6'd14: r = mk_op(SRC_PY0, SRC_PY1, 3'd1, SGN_ADD,  LAT_NONE);
         6'd15: r = mk_op(SRC_PY1, SRC_PY0, 3'd1, SGN_ADD,  LAT_NONE);
         6'd16: r = mk_op(SRC_PY1, SRC_PY1, 3'd2, SGN_ADD,  LAT_NONE);
         6'd17: r = mk_op(SRC_PZ0, SRC_PZ0, 3'd0, SGN_ADD,  LAT_NONE);
         6'd18: r = mk_op(SRC_PZ0, SRC_PZ1, 3'd1, SGN_ADD,  LAT_NONE);
         6'd19: r = mk_op(SRC_PZ1, SRC_PZ0, 3'd1, SGN_ADD,  LAT_NONE);
         6'd20: r = mk_op(SRC_PZ1, SRC_PZ1, 3'd2, SGN_ADD,  LAT_NONE);
         6'd21: r = mk_op(SRC_D,   SRC_D,   3'd0, SGN_SUB,  LAT_C);
         6'd22: r = mk_op(SRC_H0,  SRC_H0,  3'd0, SGN_ADD,  LAT_NONE);
         6'd23: r = mk_op(SRC_H0,  SRC_H1,  3'd1, SGN_ADD,  LAT_NONE);
         6'd24: r = mk_op(SRC_H0,  SRC_H2,  3'd2, SGN_ADD,  LAT_NONE);
         6'd25: r = mk_op(SRC_H1,  SRC_H0,  3'd1, SGN_ADD,  LAT_NONE);
         6'd26: r = mk_op(SRC_H1,  SRC_H1,  3'd2, SGN_ADD,  LAT_NONE);
         6'd27: r = mk_op(SRC_H1,  SRC_H2,  3'd3, SGN_ADD,  LAT_NONE);
         6'd28: r = mk_op(SRC_H2,  SRC_H0,  3'd2, SGN_ADD,  LAT_NONE);
         6'd29: r = mk_op(SRC_H2,  SRC_H1,  3'd3, SGN_ADD,  LAT_NONE);
         6'd30: r = mk_op(SRC_H2,  SRC_H2,  3'd4, SGN_ADD,  LAT_NONE);
         6'd31: r = mk_op(SRC_A0,  SRC_C0,  3'd0, SGN_SUB,  LAT_NONE);
         6'd32: r = mk_op(SRC_A0,  SRC_C1,  3'd1, SGN_SUB,  LAT_NONE);
         6'd33: r = mk_op(SRC_A0,  SRC_C2,  3'd2, SGN_SUB,  LAT_NONE);
         6'd34: r = mk_op(SRC_A1,  SRC_C0,  3'd1, SGN_SUB,  LAT_NONE);
         6'd35: r = mk_op(SRC_A1,  SRC_C1,  3'd2, SGN_SUB,  LAT_NONE);
         6'd36: r = mk_op(SRC_A1,  SRC_C2,  3'd3, SGN_SUB,  LAT_D);
         default: r = mk_op(SRC_VX, SRC_VX, 3'd0, SGN_ADD, LAT_NONE);
      endcase
      return r;
   endfunction

endpackage

>>> src/sct_mac.sv
module sct_mac
   import sct_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  rel_type  geo,
   output quad_type quad,
   output logic     done
);

   logic                  busy_ff, busy_in;
   logic [OP_W-1:0]       idx_ff, idx_in;
   logic                  s2_valid_ff, s2_valid_in;
   logic                  done_ff, done_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [SHIFT_W-1:0]    shift_ff, shift_in;
   logic                  neg_ff, neg_in;
   logic [LAT_W-1:0]      lat_ff, lat_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [A_W-1:0]        a_ff, a_in;
   logic                  a_nz_ff, a_nz_in;
   logic [HN_W-1:0]       hn_ff, hn_in;
   logic                  hn_pos_ff, hn_pos_in;
   logic [C_W-1:0]        c_ff, c_in;
   logic                  c_pos_ff, c_pos_in;
   logic [DD_W-1:0]       dd_ff, dd_in;
   logic                  dd_neg_ff, dd_neg_in;

   mac_op_type            op;
   logic [LIMB_W-1:0]     limb_vec [SRC_COUNT];
   logic [LIMB_W-1:0]     opa, opb;
   logic [ACC_W-1:0]      term, sum;

   always_comb begin
      limb_vec[SRC_VX]  = LIMB_W'(geo.v_mag[0]);
      limb_vec[SRC_VY]  = LIMB_W'(geo.v_mag[1]);
      limb_vec[SRC_VZ]  = LIMB_W'(geo.v_mag[2]);
      limb_vec[SRC_PX0] = geo.p_mag[0][LIMB_W-1:0];
      limb_vec[SRC_PX1] = LIMB_W'(geo.p_mag[0][POS_W-1:LIMB_W]);
      limb_vec[SRC_PY0] = geo.p_mag[1][LIMB_W-1:0];
      limb_vec[SRC_PY1] = LIMB_W'(geo.p_mag[1][POS_W-1:LIMB_W]);
      limb_vec[SRC_PZ0] = geo.p_mag[2][LIMB_W-1:0];
      limb_vec[SRC_PZ1] = LIMB_W'(geo.p_mag[2][POS_W-1:LIMB_W]);
      limb_vec[SRC_D]   = LIMB_W'(geo.d_sum);
      limb_vec[SRC_H0]  = hn_ff[LIMB_W-1:0];
      limb_vec[SRC_H1]  = hn_ff[2*LIMB_W-1:LIMB_W];
      limb_vec[SRC_H2]  = LIMB_W'(hn_ff[HN_W-1:2*LIMB_W]);
      limb_vec[SRC_A0]  = a_ff[LIMB_W-1:0];
      limb_vec[SRC_A1]  = LIMB_W'(a_ff[A_W-1:LIMB_W]);
      limb_vec[SRC_C0]  = c_ff[LIMB_W-1:0];
      limb_vec[SRC_C1]  = c_ff[2*LIMB_W-1:LIMB_W];
      limb_vec[SRC_C2]  = LIMB_W'(c_ff[C_W-1:2*LIMB_W]);
   end

   // stage 1: one 33x33 product per cycle
   always_comb begin
      op = mac_op(idx_ff);
      opa = (op.src_a < SRC_COUNT) ? limb_vec[op.src_a] : '0;
      opb = (op.src_b < SRC_COUNT) ? limb_vec[op.src_b] : '0;
      prod_in = opa * opb;
      shift_in = op.shift;
      lat_in = op.lat;
      unique case (op.sgn)
         SGN_ADD:  neg_in = 1'b0;
         SGN_SUB:  neg_in = 1'b1;
         SGN_NPVX: neg_in = !(geo.p_neg[0] ^ geo.v_neg[0]);
         SGN_NPVY: neg_in = !(geo.p_neg[1] ^ geo.v_neg[1]);
         SGN_NPVZ: neg_in = !(geo.p_neg[2] ^ geo.v_neg[2]);
         default:  neg_in = 1'b0;
      endcase

      busy_in = busy_ff;
      idx_in = idx_ff;
      s2_valid_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in = '0;
      end else if (busy_ff) begin
         if (idx_ff == OP_W'(OP_COUNT - 1)) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   // stage 2: shift into place and accumulate
   always_comb begin
      case (shift_ff)
         3'd0:    term = ACC_W'(prod_ff);
         3'd1:    term = ACC_W'(prod_ff) << LIMB_W;
         3'd2:    term = ACC_W'(prod_ff) << (2 * LIMB_W);
         3'd3:    term = ACC_W'(prod_ff) << (3 * LIMB_W);
         3'd4:    term = ACC_W'(prod_ff) << (4 * LIMB_W);
         default: term = '0;
      endcase
      sum = neg_ff ? (acc_ff - term) : (acc_ff + term);

      acc_in = acc_ff;
      a_in = a_ff;
      a_nz_in = a_nz_ff;
      hn_in = hn_ff;
      hn_pos_in = hn_pos_ff;
      c_in = c_ff;
      c_pos_in = c_pos_ff;
      dd_in = dd_ff;
      dd_neg_in = dd_neg_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
      end else if (s2_valid_ff) begin
         if (lat_ff == LAT_NONE) begin
            acc_in = sum;
         end else begin
            acc_in = '0;
            unique case (lat_ff)
               LAT_A: begin
                  a_in = sum[A_W-1:0];
                  a_nz_in = |sum[A_W-1:0];
               end
               LAT_H: begin
                  hn_in = sum[HN_W-1:0];
                  hn_pos_in = !sum[ACC_W-1] && (|sum);
               end
               LAT_C: begin
                  c_in = sum[C_W-1:0];
                  c_pos_in = !sum[ACC_W-1] && (|sum);
               end
               LAT_D: begin
                  dd_in = sum[DD_W-1:0];
                  dd_neg_in = sum[ACC_W-1];
                  done_in = 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
         s2_valid_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
         s2_valid_ff <= s2_valid_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      shift_ff <= shift_in;
      neg_ff <= neg_in;
      lat_ff <= lat_in;
      acc_ff <= acc_in;
      a_ff <= a_in;
      a_nz_ff <= a_nz_in;
      hn_ff <= hn_in;
      hn_pos_ff <= hn_pos_in;
      c_ff <= c_in;
      c_pos_ff <= c_pos_in;
      dd_ff <= dd_in;
      dd_neg_ff <= dd_neg_in;
   end

   assign quad.a = a_ff;
   assign quad.hn = hn_ff;
   assign quad.dd = dd_ff;
   assign quad.a_nz = a_nz_ff;
   assign quad.hn_pos = hn_pos_ff;
   assign quad.c_pos = c_pos_ff;
   assign quad.dd_neg = dd_neg_ff;
   assign done = done_ff;

endmodule

>>> src/sct_rootdiv.sv
module sct_rootdiv
   import sct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  quad_type          quad,
   output logic              done,
   output logic [TIME_W-1:0] quot
);

   localparam logic [1:0] RD_IDLE = 2'd0;
   localparam logic [1:0] RD_ROOT = 2'd1;
   localparam logic [1:0] RD_NUM  = 2'd2;
   localparam logic [1:0] RD_DIV  = 2'd3;

   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DD_W-1:0]  rem_ff, rem_in;
   logic [DD_W-1:0]  res_ff, res_in;
   logic [DD_W-1:0]  probe_ff, probe_in;

   logic [DD_W-1:0]  x_op, y_op, diff;
   logic [DD_W:0]    diff_full;
   logic             ge;

   // shared compare-subtract
   always_comb begin
      unique case (phase_ff)
         RD_ROOT: begin
            x_op = rem_ff;
            y_op = res_ff | probe_ff;
         end
         RD_NUM: begin
            x_op = DD_W'(quad.hn);
            y_op = res_ff;
         end
         RD_DIV: begin
            x_op = rem_ff;
            y_op = probe_ff;
         end
         default: begin
            x_op = rem_ff;
            y_op = '0;
         end
      endcase
      diff_full = {1'b0, x_op} - {1'b0, y_op};
      ge = !diff_full[DD_W];
      diff = diff_full[DD_W-1:0];
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      res_in = res_ff;
      probe_in = probe_ff;
      done_in = 1'b0;
      unique case (phase_ff)
         RD_IDLE: begin
            if (start) begin
               rem_in = quad.dd;
               res_in = '0;
               probe_in = DD_W'(1) << ROOT_BIT0;
               cnt_in = CNT_W'(ROOT_STEPS - 1);
               phase_in = RD_ROOT;
            end
         end
         RD_ROOT: begin
            if (ge) begin
               rem_in = diff;
               res_in = (res_ff >> 1) | probe_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            probe_in = probe_ff >> 2;
            if (cnt_ff == '0) begin
               phase_in = RD_NUM;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         RD_NUM: begin
            rem_in = diff << FRAC_W;
            probe_in = DD_W'(quad.a) << TIME_W;
            res_in = '0;
            cnt_in = CNT_W'(DIV_STEPS - 1);
            phase_in = RD_DIV;
         end
         RD_DIV: begin
            if (ge) begin
               rem_in = diff;
               res_in = (res_ff << 1) | DD_W'(1);
            end else begin
               res_in = res_ff << 1;
            end
            probe_in = probe_ff >> 1;
            if (cnt_ff == '0) begin
               phase_in = RD_IDLE;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: phase_in = RD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RD_IDLE;
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      probe_ff <= probe_in;
   end

   // quotient bit 32 set means the time does not fit: saturate
   assign quot = res_ff[TIME_W] ? '1 : res_ff[TIME_W-1:0];
   assign done = done_ff;

endmodule

>>> src/sphere_collision_time_unit.sv
// Moving sphere-sphere time of impact.
// req channel: one word per sphere. req_tuser 0 loads the reference sphere
// (position, velocity, radius), 1 tests the given sphere against it.
// rsp channel: one word per test word, the time to first contact in ticks,
// unsigned Q16.16, 0 for no contact, all ones when it does not fit.
// A load word gives no rsp word. A test word passes through the states
// ST_ABS, ST_MAC, ST_ROOT (skipped when contact is ruled out early) and
// ST_DONE; req_tready rises together with rsp_tvalid, when the result is
// written to the rsp register. The time is computed by 37 passes through
// the shared 33x33 multiply-accumulate, an 82-step square root and a 33-step
// restoring divide that share one 164-bit compare-subtract unit.
// The rsp register holds its word while rsp_tready is low; a new word may be
// accepted meanwhile, and its result waits until the register is free.
// Reset (synchronous) clears the reference sphere to all zeros, empties the
// rsp register and returns the block to idle.
module sphere_collision_time_unit
   import sct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // impact_time
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int VEL_OFS = 3 * POS_W;
   localparam int RAD_OFS = 3 * POS_W + 3 * VEL_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ABS  = 3'd1;
   localparam logic [2:0] ST_MAC  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [2:0][POS_W-1:0]  ref_pos_ff, ref_pos_in;
   logic [2:0][VEL_W-1:0]  ref_vel_ff, ref_vel_in;
   logic [RAD_W-1:0]       ref_rad_ff, ref_rad_in;
   logic [2:0][PDIF_W-1:0] pdiff_ff, pdiff_in;
   logic [2:0][VDIF_W-1:0] vdiff_ff, vdiff_in;
   logic [DSUM_W-1:0]      dsum_ff, dsum_in;
   rel_type                rel_ff, rel_in;
   logic [TIME_W-1:0]      result_ff, result_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [2:0][POS_W-1:0]  in_pos;
   logic [2:0][VEL_W-1:0]  in_vel;
   logic [RAD_W-1:0]       in_rad;
   logic [2:0][PDIF_W-1:0] pabs;
   logic [2:0][VDIF_W-1:0] vabs;
   logic                   req_accept;
   logic                   mac_start, mac_done;
   logic                   rd_start, rd_done;
   logic                   hit_ok;
   quad_type               quad;
   logic [TIME_W-1:0]      rd_quot;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign mac_start = (state_ff == ST_ABS);
   assign hit_ok = quad.a_nz && quad.hn_pos && quad.c_pos && !quad.dd_neg;
   assign rd_start = (state_ff == ST_MAC) && mac_done && hit_ok;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         in_pos[k] = req_tdata[k*POS_W +: POS_W];
         in_vel[k] = req_tdata[VEL_OFS + k*VEL_W +: VEL_W];
         pdiff_in[k] = {ref_pos_ff[k][POS_W-1], ref_pos_ff[k]}
                     - {in_pos[k][POS_W-1], in_pos[k]};
         vdiff_in[k] = {ref_vel_ff[k][VEL_W-1], ref_vel_ff[k]}
                     - {in_vel[k][VEL_W-1], in_vel[k]};
         pabs[k] = pdiff_ff[k][PDIF_W-1] ? (~pdiff_ff[k] + 1'b1) : pdiff_ff[k];
         vabs[k] = vdiff_ff[k][VDIF_W-1] ? (~vdiff_ff[k] + 1'b1) : vdiff_ff[k];
         rel_in.p_mag[k] = pabs[k][POS_W-1:0];
         rel_in.p_neg[k] = pdiff_ff[k][PDIF_W-1];
         rel_in.v_mag[k] = vabs[k][VEL_W-1:0];
         rel_in.v_neg[k] = vdiff_ff[k][VDIF_W-1];
      end
      in_rad = req_tdata[RAD_OFS +: RAD_W];
      dsum_in = {1'b0, ref_rad_ff} + {1'b0, in_rad};
      rel_in.d_sum = dsum_ff;
   end

   always_comb begin
      state_in = state_ff;
      ref_pos_in = ref_pos_ff;
      ref_vel_in = ref_vel_ff;
      ref_rad_in = ref_rad_ff;
      result_in = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == KIND_LOAD) begin
                  ref_pos_in = in_pos;
                  ref_vel_in = in_vel;
                  ref_rad_in = in_rad;
               end else begin
                  state_in = ST_ABS;
               end
            end
         end
         ST_ABS: state_in = ST_MAC;
         ST_MAC: begin
            if (mac_done) begin
               if (hit_ok) begin
                  state_in = ST_ROOT;
               end else begin
                  result_in = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_ROOT: begin
            if (rd_done) begin
               result_in = rd_quot;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = result_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ref_pos_ff <= '0;
         ref_vel_ff <= '0;
         ref_rad_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ref_pos_ff <= ref_pos_in;
         ref_vel_ff <= ref_vel_in;
         ref_rad_ff <= ref_rad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pdiff_ff <= pdiff_in;
         vdiff_ff <= vdiff_in;
         dsum_ff <= dsum_in;
      end
      if (state_ff == ST_ABS) begin
         rel_ff <= rel_in;
      end
      result_ff <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   sct_mac u_mac (
      .clock (clock),
      .reset (reset),
      .start (mac_start),
      .geo   (rel_ff),
      .quad  (quad),
      .done  (mac_done)
   );

   sct_rootdiv u_rootdiv (
      .clock (clock),
      .reset (reset),
      .start (rd_start),
      .quad  (quad),
      .done  (rd_done),
      .quot  (rd_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   mac_done_in_mac: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_MAC)
      else $error("quadratic terms finished outside the multiply phase");

   rd_done_in_root: assert property (@(posedge clock) disable iff (reset)
      rd_done |-> state_ff == ST_ROOT)
      else $error("root/divide finished outside its phase");

   rsp_load_value: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready))
      |=> rsp_valid_ff && rsp_data_ff == $past(result_ff))
      else $error("result word not moved into the rsp register");

endmodule

>>> tb/sphere_collision_time_unit_tb.sv
module sphere_collision_time_unit_tb
   import sct_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TEST_LATENCY = 160;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int HOLD_CYCLES = 1200;
   localparam longint POS_MAX = (longint'(1) <<< (POS_W - 1)) - 1;
   localparam longint POS_MIN = -(longint'(1) <<< (POS_W - 1));
   localparam longint VEL_MAX = (longint'(1) <<< (VEL_W - 1)) - 1;
   localparam longint VEL_MIN = -(longint'(1) <<< (VEL_W - 1));

   typedef struct {
      logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
      logic signed [VEL_W-1:0] vel_x, vel_y, vel_z;
      logic [RAD_W-1:0]        radius;
   } sphere_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = KIND_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   sphere_type            ref_sphere = '{default: '0};
   logic [TIME_W-1:0]     impact_q[$];
   logic [TIME_W-1:0]     checked_time;
   int                    send_idle_pct = 6;
   int                    rsp_idle_pct = 85;
   int                    hold_request = 0;
   int                    hold_left = 0;
   int                    stall_cycles = 0;
   int                    error_count = 0;
   int                    words_sent = 0;
   int                    loads_sent = 0;
   int                    contact_count = 0;
   int                    saturated_count = 0;
   int                    no_contact_count = 0;

   sphere_collision_time_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // earliest contact time against the stored reference sphere, Q16.16 ticks
   function automatic logic [TIME_W-1:0] predict_impact_time(sphere_type s);
      logic signed [255:0] px, py, pz, vx, vy, vz, d, a, h, c, hn, dd;
      logic [255:0]        rem, root, probe, num;
      px = ref_sphere.pos_x - s.pos_x;
      py = ref_sphere.pos_y - s.pos_y;
      pz = ref_sphere.pos_z - s.pos_z;
      vx = ref_sphere.vel_x - s.vel_x;
      vy = ref_sphere.vel_y - s.vel_y;
      vz = ref_sphere.vel_z - s.vel_z;
      d = ref_sphere.radius + s.radius;
      a = vx * vx + vy * vy + vz * vz;
      h = px * vx + py * vy + pz * vz;
      c = px * px + py * py + pz * pz - d * d;
      if (a == 0 || h >= 0 || c <= 0) return '0;
      hn = -h;
      dd = hn * hn - a * c;
      if (dd < 0) return '0;
      // floor(sqrt(dd)), one root bit per pass
      rem = dd;
      root = '0;
      for (int i = 127; i >= 0; i--) begin
         probe = root + (256'(1) << (2 * i));
         if (rem >= probe) begin
            rem = rem - probe;
            root = (root >> 1) + (256'(1) << (2 * i));
         end else begin
            root = root >> 1;
         end
      end
      num = (hn - root) << FRAC_W;
      if (num >= (a << TIME_W)) return '1;
      return TIME_W'(num / a);
   endfunction

   function automatic sphere_type mk_sphere(longint px, longint py, longint pz,
                                            longint vx, longint vy, longint vz,
                                            int unsigned r);
      sphere_type s;
      s.pos_x = px[POS_W-1:0];
      s.pos_y = py[POS_W-1:0];
      s.pos_z = pz[POS_W-1:0];
      s.vel_x = vx[VEL_W-1:0];
      s.vel_y = vy[VEL_W-1:0];
      s.vel_z = vz[VEL_W-1:0];
      s.radius = r;
      return s;
   endfunction

   function automatic longint rand_signed(int bits);
      longint x;
      x = {$urandom(), $urandom()};
      return x >>> (64 - bits);
   endfunction

   task automatic send_word(logic kind, sphere_type s);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {s.radius, s.vel_z, s.vel_y, s.vel_x, s.pos_z, s.pos_y, s.pos_x};
      do @(posedge clock); while (req_tready !== 1'b1);
      words_sent++;
      if (kind == KIND_LOAD) begin
         ref_sphere = s;
         loads_sent++;
      end else begin
         impact_q.push_back(predict_impact_time(s));
      end
   endtask

   // test word given by its offset and velocity relative to the reference
   task automatic send_rel(longint px, longint py, longint pz,
                           longint vx, longint vy, longint vz, int unsigned r);
      send_word(KIND_TEST, mk_sphere(longint'(ref_sphere.pos_x) - px,
                                     longint'(ref_sphere.pos_y) - py,
                                     longint'(ref_sphere.pos_z) - pz,
                                     longint'(ref_sphere.vel_x) - vx,
                                     longint'(ref_sphere.vel_y) - vy,
                                     longint'(ref_sphere.vel_z) - vz, r));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (impact_q.size() == 0);
      repeat (TEST_LATENCY) @(posedge clock);
   endtask

   // new reference, then spheres heading roughly at it
   task automatic send_approach_set();
      longint ux, uy, uz, m, sp, nx, ny, nz;
      send_word(KIND_LOAD, mk_sphere(rand_signed(45), rand_signed(45), rand_signed(45),
                                     rand_signed(29), rand_signed(29), rand_signed(29),
                                     $urandom_range(0, 1 << 20)));
      repeat ($urandom_range(2, 6)) begin
         ux = longint'($urandom_range(0, 2000)) - 1000;
         uy = longint'($urandom_range(0, 2000)) - 1000;
         uz = longint'($urandom_range(0, 2000)) - 1000;
         m = longint'($urandom_range(1, 1 << $urandom_range(0, 24)));
         sp = longint'($urandom_range(1, 1 << $urandom_range(0, 12)));
         nx = 0;
         ny = 0;
         nz = 0;
         if ($urandom_range(0, 3) == 0) begin
            nx = longint'($urandom_range(0, 64)) - 32;
            ny = longint'($urandom_range(0, 64)) - 32;
            nz = longint'($urandom_range(0, 64)) - 32;
         end
         send_rel(ux * m, uy * m, uz * m, nx - ux * sp, ny - uy * sp, nz - uz * sp,
                  $urandom_range(0, 1 << $urandom_range(0, 20)));
      end
   endtask

   task automatic send_noise_word();
      sphere_type s;
      s.pos_x = POS_W'({$urandom(), $urandom()});
      s.pos_y = POS_W'({$urandom(), $urandom()});
      s.pos_z = POS_W'({$urandom(), $urandom()});
      s.vel_x = $urandom();
      s.vel_y = $urandom();
      s.vel_z = $urandom();
      s.radius = $urandom();
      send_word($urandom_range(0, 1) ? KIND_TEST : KIND_LOAD, s);
   endtask

   task automatic test_before_load();
      send_rel(100000, 0, 0, -1000, 0, 0, 10);
   endtask

   task automatic test_special_cases();
      send_word(KIND_LOAD, mk_sphere(1000, -2000, 3000, 10, 20, -30, 100));
      send_rel(5000, 0, 0, 0, 0, 0, 50);               // no relative motion
      send_rel(100, 0, 0, -7, 0, 0, 50);               // overlapping
      send_rel(150, 0, 0, -7, 0, 0, 50);               // just touching
      send_rel(5000, 0, 0, 9, 0, 0, 50);               // moving apart
      send_rel(5000, 0, 0, 0, 9, 0, 50);               // side by side
      send_rel(5000, 5000, 0, -9, 0, 0, 50);           // passes wide
      send_rel(5000, 150, 0, -10, 0, 0, 50);           // grazing, zero discriminant
      send_rel(1150, 0, 0, -3, 0, 0, 50);              // fractional time
      send_rel(151, 0, 0, -(longint'(1) <<< 30), 0, 0, 50); // rounds to zero
      send_rel(150 + 65535, 0, 0, -1, 0, 0, 50);       // largest unsaturated
      send_rel(150 + 65536, 0, 0, -1, 0, 0, 50);       // saturates
      send_rel(longint'(1) <<< 40, 0, 0, -1, 0, 0, 50);
   endtask

   task automatic test_field_extremes();
      send_word(KIND_LOAD, mk_sphere(POS_MAX, POS_MAX, POS_MAX,
                                     VEL_MIN, VEL_MIN, VEL_MIN, 32'hFFFF_FFFF));
      send_word(KIND_TEST, mk_sphere(POS_MIN, POS_MIN, POS_MIN,
                                     VEL_MAX, VEL_MAX, VEL_MAX, 32'hFFFF_FFFF));
      send_word(KIND_LOAD, mk_sphere(POS_MIN, POS_MIN, POS_MIN,
                                     VEL_MAX, VEL_MAX, VEL_MAX, 0));
      send_word(KIND_TEST, mk_sphere(POS_MAX, POS_MAX, POS_MAX,
                                     VEL_MIN, VEL_MIN, VEL_MIN, 0));
      send_word(KIND_LOAD, mk_sphere(0, 0, 0, 0, 0, 0, 0));
      send_word(KIND_TEST, mk_sphere(0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random_traffic(int n_words);
      int start;
      start = words_sent;
      while (words_sent - start < n_words) begin
         if ($urandom_range(0, 4) != 0) send_approach_set();
         else repeat ($urandom_range(1, 4)) send_noise_word();
      end
   endtask

   // rsp side stalls long enough to back the block up into req
   task automatic test_result_backpressure();
      hold_request = HOLD_CYCLES;
      repeat (2) send_approach_set();
      wait_for_results();
   endtask

   task automatic test_paused_sender();
      repeat (3) begin
         send_approach_set();
         wait_for_results();
      end
   endtask

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (impact_q.size() == 0) begin
            $error("unexpected rsp word: impact_time 0x%08h", rsp_tdata);
            error_count++;
         end else begin
            checked_time = impact_q.pop_front();
            if (rsp_tdata !== checked_time) begin
               $error("impact_time mismatch: expected 0x%08h, actual 0x%08h",
                      checked_time, rsp_tdata);
               error_count++;
            end
            if (checked_time == '0) no_contact_count++;
            else if (checked_time == '1) saturated_count++;
            else contact_count++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_before_load();
      test_special_cases();
      test_field_extremes();
      test_random_traffic(190);
      wait_for_results();

      send_idle_pct = 85;
      rsp_idle_pct = 6;
      test_random_traffic(190);
      wait_for_results();

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_traffic(190);
      test_result_backpressure();
      test_paused_sender();
      wait_for_results();

      $display("%0d req words (%0d loads, %0d tests) incl. extremes and corner geometry",
               words_sent, loads_sent, words_sent - loads_sent);
      $display("rsp words: %0d contacts, %0d saturated, %0d no contact, %0d errors",
               contact_count, saturated_count, no_contact_count, error_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
